[sv/dotq_pkg.sv]
// -----------------------------------------------------------------------------
// dotq_pkg
// Shared constants, codes and the result record of the deadline-ordered queue.
// -----------------------------------------------------------------------------
package dotq_pkg;

	// Default sizes for the top-level parameters.
	localparam int QUEUE_DEPTH_DEF = 64;
	localparam int ID_WIDTH_DEF    = 16;

	// Fixed field widths of the stream payloads.
	localparam int DUE_W    = 32;
	localparam int OUT_ID_W = 16;
	localparam int CAP_W    = 7;

	// Per-tick release limit and the cap register's reset value.
	localparam int            MAX_RESULTS = 64;
	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	// Request command codes.
	localparam logic CMD_ADD  = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	// Result kind codes.
	localparam logic [1:0] KIND_ADD   = 2'd0;
	localparam logic [1:0] KIND_REL   = 2'd1;
	localparam logic [1:0] KIND_EMPTY = 2'd2;

	// One result as handed from the sequencer to the output register.
	typedef struct packed {
		logic [1:0]          kind;
		logic [OUT_ID_W-1:0] id;
		logic [DUE_W-1:0]    due;
		logic                status;
		logic                last;
	} res_t;

endpackage

[sv/dotq_mem.sv]
// -----------------------------------------------------------------------------
// dotq_mem
// Single-write, single-read entry memory with a registered read port.
// -----------------------------------------------------------------------------
module dotq_mem #(
	parameter int DEPTH = dotq_pkg::QUEUE_DEPTH_DEF,
	parameter int WIDTH = dotq_pkg::ID_WIDTH_DEF + dotq_pkg::DUE_W
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata_q
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

endmodule

[sv/dotq_obuf.sv]
// -----------------------------------------------------------------------------
// dotq_obuf
// Output register that decouples the sequencer from the downstream stream.
// -----------------------------------------------------------------------------
module dotq_obuf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                res_valid,
	output logic                res_ready,
	input  dotq_pkg::res_t      res,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [47:0]         m_tdata,
	output logic [2:0]          m_tuser,
	output logic                m_tlast
);

	logic           valid_q;
	dotq_pkg::res_t res_q;

	// The register can take a new result when empty or being drained.
	assign res_ready = !valid_q || m_tready;

	// Valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	// Payload.
	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			res_q <= res;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {res_q.due, res_q.id};
	assign m_tuser  = {res_q.status, res_q.kind};
	assign m_tlast  = res_q.last;

endmodule

[sv/dotq_seq.sv]
// -----------------------------------------------------------------------------
// dotq_seq
// Sequencer that inserts and releases tasks through one shared due comparator.
// -----------------------------------------------------------------------------
module dotq_seq #(
	parameter int QUEUE_DEPTH = dotq_pkg::QUEUE_DEPTH_DEF,
	parameter int ID_WIDTH    = dotq_pkg::ID_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Request side
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 in_cmd,
	input  logic [dotq_pkg::OUT_ID_W-1:0]        in_id,
	input  logic [dotq_pkg::DUE_W-1:0]           in_due,
	input  logic [dotq_pkg::CAP_W-1:0]           cap,
	// Entry memory
	output logic                                 mem_we,
	output logic [$clog2(QUEUE_DEPTH)-1:0]       mem_waddr,
	output logic [ID_WIDTH+dotq_pkg::DUE_W-1:0]  mem_wdata,
	output logic                                 mem_re,
	output logic [$clog2(QUEUE_DEPTH)-1:0]       mem_raddr,
	input  logic [ID_WIDTH+dotq_pkg::DUE_W-1:0]  mem_rdata,
	// Result side
	output logic                                 res_valid,
	input  logic                                 res_ready,
	output dotq_pkg::res_t                       res
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int DW = dotq_pkg::DUE_W;
	localparam int EW = ID_WIDTH + DW;
	localparam logic [CW:0]   DEPTH_S = (CW + 1)'(QUEUE_DEPTH);
	localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
	localparam logic [AW-1:0] LAST_IX = AW'(QUEUE_DEPTH - 1);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_ARD  = 7'b0000010,
		ST_ACMP = 7'b0000100,
		ST_ADONE = 7'b0001000,
		ST_TRD  = 7'b0010000,
		ST_TCMP = 7'b0100000,
		ST_TFIN = 7'b1000000
	} state_t;

	state_t                          state_q, state_d;
	logic [AW-1:0]                   head_q, head_d;
	logic [CW-1:0]                   count_q, count_d;
	logic [CW-1:0]                   k_q, k_d;
	logic [DW-1:0]                   cur_q, cur_d;
	logic [dotq_pkg::CAP_W-1:0]      n_q, n_d;
	logic                            pend_v_q, pend_v_d;
	logic [EW-1:0]                   pend_q, pend_d;
	logic [ID_WIDTH-1:0]             new_id_q, new_id_d;
	logic [DW-1:0]                   new_due_q, new_due_d;
	logic                            status_q, status_d;

	logic [DW-1:0]                   cmp_a, cmp_b;
	logic                            cmp_gt;
	logic [dotq_pkg::CAP_W-1:0]      cap_eff;
	logic [ID_WIDTH+15:0]            id_in_ext;
	logic [ID_WIDTH+15:0]            new_id_ext;
	logic [ID_WIDTH+15:0]            pend_id_ext;
	logic [CW:0]                     rsum, rsel, wsum, wsel;
	logic [AW-1:0]                   rd_idx, wr_idx, head_nx;
	logic [EW-1:0]                   new_entry;

	// Shared due comparator: clamp check on accept, insert walk, release check.
	assign cmp_a  = (state_q == ST_IDLE) ? in_due : mem_rdata[DW-1:0];
	assign cmp_b  = (state_q == ST_ACMP) ? new_due_q : cur_q;
	assign cmp_gt = cmp_a > cmp_b;

	// Effective per-tick cap, limited to one through the maximum.
	always_comb begin
		if (cap == '0) begin
			cap_eff = dotq_pkg::CAP_W'(1);
		end else if (cap > dotq_pkg::CAP_W'(dotq_pkg::MAX_RESULTS)) begin
			cap_eff = dotq_pkg::CAP_W'(dotq_pkg::MAX_RESULTS);
		end else begin
			cap_eff = cap;
		end
	end

	// Id width conversions between the stream fields and stored entries.
	assign id_in_ext   = {{ID_WIDTH{1'b0}}, in_id};
	assign new_id_ext  = {16'b0, new_id_q};
	assign pend_id_ext = {16'b0, pend_q[EW-1:DW]};
	assign new_entry   = {new_id_q, new_due_q};

	// Ring addresses: read slot k-1 and write slot k, relative to the head.
	always_comb begin
		rsum    = (CW + 1)'(head_q) + (CW + 1)'(k_q - CW'(1));
		rsel    = (rsum >= DEPTH_S) ? rsum - DEPTH_S : rsum;
		rd_idx  = rsel[AW-1:0];
		wsum    = (CW + 1)'(head_q) + (CW + 1)'(k_q);
		wsel    = (wsum >= DEPTH_S) ? wsum - DEPTH_S : wsum;
		wr_idx  = wsel[AW-1:0];
		head_nx = (head_q == LAST_IX) ? '0 : head_q + AW'(1);
	end

	// Sequencer next state and datapath control.
	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		count_d   = count_q;
		k_d       = k_q;
		cur_d     = cur_q;
		n_d       = n_q;
		pend_v_d  = pend_v_q;
		pend_d    = pend_q;
		new_id_d  = new_id_q;
		new_due_d = new_due_q;
		status_d  = status_q;
		in_ready  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = wr_idx;
		mem_wdata = new_entry;
		mem_re    = 1'b0;
		mem_raddr = rd_idx;
		res_valid = 1'b0;
		res       = '{kind: dotq_pkg::KIND_ADD, id: new_id_ext[15:0], due: new_due_q,
			status: status_q, last: 1'b1};

		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_cmd == dotq_pkg::CMD_TICK) begin
						n_d      = '0;
						pend_v_d = 1'b0;
						state_d  = ST_TRD;
					end else begin
						new_id_d  = id_in_ext[ID_WIDTH-1:0];
						new_due_d = cmp_gt ? in_due : cur_q + DW'(1);
						if (count_q == DEPTH_C) begin
							status_d = 1'b1;
							state_d  = ST_ADONE;
						end else begin
							status_d = 1'b0;
							k_d      = count_q;
							state_d  = ST_ARD;
						end
					end
				end
			end
			ST_ARD: begin
				if (k_q == '0) begin
					mem_we  = 1'b1;
					count_d = count_q + CW'(1);
					state_d = ST_ADONE;
				end else begin
					mem_re  = 1'b1;
					state_d = ST_ACMP;
				end
			end
			ST_ACMP: begin
				// A later entry moves one slot back; otherwise the new task lands here.
				mem_we = 1'b1;
				if (cmp_gt) begin
					mem_wdata = mem_rdata;
					k_d       = k_q - CW'(1);
					state_d   = ST_ARD;
				end else begin
					count_d = count_q + CW'(1);
					state_d = ST_ADONE;
				end
			end
			ST_ADONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			ST_TRD: begin
				mem_raddr = head_q;
				if ((count_q != '0) && (n_q < cap_eff)) begin
					mem_re  = 1'b1;
					state_d = ST_TCMP;
				end else begin
					state_d = ST_TFIN;
				end
			end
			ST_TCMP: begin
				// The held release goes out once another due task is seen.
				res = '{kind: dotq_pkg::KIND_REL, id: pend_id_ext[15:0],
					due: pend_q[DW-1:0], status: 1'b0, last: 1'b0};
				if (!cmp_gt) begin
					res_valid = pend_v_q;
					if (!pend_v_q || res_ready) begin
						pend_d   = mem_rdata;
						pend_v_d = 1'b1;
						head_d   = head_nx;
						count_d  = count_q - CW'(1);
						n_d      = n_q + dotq_pkg::CAP_W'(1);
						state_d  = ST_TRD;
					end
				end else begin
					state_d = ST_TFIN;
				end
			end
			ST_TFIN: begin
				res_valid = 1'b1;
				if (pend_v_q) begin
					res = '{kind: dotq_pkg::KIND_REL, id: pend_id_ext[15:0],
						due: pend_q[DW-1:0], status: 1'b0, last: 1'b1};
				end else begin
					res = '{kind: dotq_pkg::KIND_EMPTY, id: '0, due: cur_q,
						status: 1'b0, last: 1'b1};
				end
				if (res_ready) begin
					cur_d   = cur_q + DW'(1);
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			head_q   <= '0;
			count_q  <= '0;
			cur_q    <= '0;
			pend_v_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			head_q   <= head_d;
			count_q  <= count_d;
			cur_q    <= cur_d;
			pend_v_q <= pend_v_d;
		end
	end

	// Working registers of the current request.
	always_ff @(posedge clk) begin
		k_q       <= k_d;
		n_q       <= n_d;
		pend_q    <= pend_d;
		new_id_q  <= new_id_d;
		new_due_q <= new_due_d;
		status_q  <= status_d;
	end

endmodule

[sv/deadline_ordered_task_queue.sv]
// -----------------------------------------------------------------------------
// deadline_ordered_task_queue
// Task queue sorted by due cycle, with FIFO order among equal due cycles.
// -----------------------------------------------------------------------------
// Requests arrive on the s_ stream: s_tuser is the command (add or tick), and
// s_tdata carries the task id and due cycle. Results leave on the m_ stream:
// m_tuser gives kind and drop status, m_tdata the id and stored due cycle, and
// m_tlast marks the final result of each request. cfg_we/cfg_wdata write the
// per-tick release cap; the user must do so only while the block is idle,
// which the block does not enforce. One request is in work at a time;
// s_tready is high only when the sequencer is idle. An add walks back from
// the tail, one entry per read/compare state pair, moving each later task
// one slot back until the new task's place is found. A full queue drops the
// add with the drop status set. A tick releases due tasks from the head, one
// per read/compare state pair, and ends at the cap, at an empty queue or at
// the first task not yet due, then advances the cycle count. Each result
// shows on m_tvalid in the cycle after the sequencer hands it over. Results
// pass through one output register; when the receiver stalls, the sequencer
// waits on it and no further request is taken until all results of the
// current one are handed over. Reset empties the queue, clears the cycle
// count and sets the cap to 64; the entry memory itself needs no clearing.
// -----------------------------------------------------------------------------
module deadline_ordered_task_queue #(
	parameter int QUEUE_DEPTH = dotq_pkg::QUEUE_DEPTH_DEF,
	parameter int ID_WIDTH    = dotq_pkg::ID_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // task_id[15:0], due_cycle[47:16]
	input  logic [0:0]  s_tuser,   // cmd[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // released_id[15:0], released_due[47:16]
	output logic [2:0]  m_tuser,   // kind[1:0], status[2]
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [6:0]  cfg_wdata
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int EW = ID_WIDTH + dotq_pkg::DUE_W;

	logic [dotq_pkg::CAP_W-1:0] cap_q;
	logic                       mem_we, mem_re;
	logic [AW-1:0]              mem_waddr, mem_raddr;
	logic [EW-1:0]              mem_wdata, mem_rdata;
	logic                       res_valid, res_ready;
	dotq_pkg::res_t             res;

	// Per-tick cap register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= dotq_pkg::CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// Insert and release sequencer.
	dotq_seq #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.ID_WIDTH(ID_WIDTH)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_cmd(s_tuser[0]),
		.in_id(s_tdata[15:0]),
		.in_due(s_tdata[47:16]),
		.cap(cap_q),
		.mem_we(mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_re(mem_re),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res)
	);

	// Entry memory, kept as a ring starting at the queue head.
	dotq_mem #(
		.DEPTH(QUEUE_DEPTH),
		.WIDTH(EW)
	) u_mem (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re(mem_re),
		.raddr(mem_raddr),
		.rdata_q(mem_rdata)
	);

	// Result output register.
	dotq_obuf u_obuf (
		.clk(clk),
		.arst_n(arst_n),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	// After a request is accepted, s_tready is low in the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while the previous one was still starting");

	// An add acknowledge is always the only result of its request.
	a_add_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[1:0] == dotq_pkg::KIND_ADD) |-> m_tlast)
		else $error("add acknowledge without end-of-request mark");

	// Only a dropped add may carry the full status.
	a_status_on_add: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2] |-> (m_tuser[1:0] == dotq_pkg::KIND_ADD))
		else $error("drop status on a result that is not an add acknowledge");

	// An empty tick marker carries no task id.
	a_empty_no_id: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[1:0] == dotq_pkg::KIND_EMPTY) |-> (m_tdata[15:0] == 16'd0))
		else $error("empty tick marker with a task id");

endmodule

[tb/sv/tb_deadline_ordered_task_queue.sv]
// -----------------------------------------------------------------------------
// tb_deadline_ordered_task_queue
// Self-checking stream testbench for the deadline-ordered task queue.
// -----------------------------------------------------------------------------
// Add and tick requests go in on the s_ stream. Each accepted request is run
// through a behavioral copy of the queue kept here: a sorted list of tasks,
// the cycle count and the release cap. That copy yields the expected results,
// which are then matched in order against the m_ stream. The run covers queue
// overflow, FIFO order among equal due cycles, due clamping, cap settings at
// and beyond both ends, a long receiver stall, and random traffic under
// several sender and receiver idle patterns.
// -----------------------------------------------------------------------------
module tb_deadline_ordered_task_queue;

	localparam int LIMIT_CYCLES  = 400000;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES   = 300;
	localparam int RANDOM_ITEMS  = 5;

	typedef struct packed {
		logic [dotq_pkg::OUT_ID_W-1:0] id;
		logic [dotq_pkg::DUE_W-1:0]    due;
	} sched_entry_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;   // task_id[15:0], due_cycle[47:16]
	logic [0:0]  s_tuser;   // cmd[0]
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;   // released_id[15:0], released_due[47:16]
	logic [2:0]  m_tuser;   // kind[1:0], status[2]
	logic        m_tlast;
	logic        cfg_we;
	logic [6:0]  cfg_wdata;

	// Behavioral copy of the queue state.
	sched_entry_t                   scheduled_tasks[$];
	logic [dotq_pkg::DUE_W-1:0]     now_cycle;
	logic [dotq_pkg::CAP_W-1:0]     release_cap;
	dotq_pkg::res_t                 expected_results[$];

	int send_idle_pct;
	int recv_stall_pct;
	bit hold_off;
	int cycle_count;
	int mismatch_count;
	int requests_sent;
	int results_checked;

	deadline_ordered_task_queue uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Abort a hung run.
	initial begin
		wait (cycle_count >= LIMIT_CYCLES);
		$display("Timeout after %0d cycles, %0d results still awaited.", cycle_count,
			expected_results.size());
		$display("[deadline_ordered_task_queue] ERROR");
		$finish;
	end

	// Append one expected result behind the ones already waiting.
	function automatic void queue_result(dotq_pkg::res_t r);
		expected_results.insert(expected_results.size(), r);
	endfunction

	// Update the queue copy for one accepted request and queue its results.
	function automatic void predict_response(logic cmd, logic [15:0] id, logic [31:0] due);
		sched_entry_t   entry;
		dotq_pkg::res_t r;
		int             pos;
		int             cap;
		int             n;
		if (cmd == dotq_pkg::CMD_ADD) begin
			entry.id  = id;
			entry.due = (due <= now_cycle) ? now_cycle + 32'd1 : due;
			r.kind    = dotq_pkg::KIND_ADD;
			r.id      = entry.id;
			r.due     = entry.due;
			r.last    = 1'b1;
			if (scheduled_tasks.size() >= dotq_pkg::QUEUE_DEPTH_DEF) begin
				r.status = 1'b1;
			end else begin
				// Insert after every task due at or before this one.
				pos = 0;
				while (pos < scheduled_tasks.size() && scheduled_tasks[pos].due <= entry.due)
					pos++;
				scheduled_tasks.insert(pos, entry);
				r.status = 1'b0;
			end
			queue_result(r);
		end else begin
			cap = int'(release_cap);
			if (cap < 1)
				cap = 1;
			if (cap > dotq_pkg::MAX_RESULTS)
				cap = dotq_pkg::MAX_RESULTS;
			n = 0;
			while (n < scheduled_tasks.size() && n < cap && scheduled_tasks[n].due <= now_cycle)
				n++;
			for (int k = 0; k < n; k++) begin
				entry = scheduled_tasks[0];
				scheduled_tasks.delete(0);
				r.kind   = dotq_pkg::KIND_REL;
				r.id     = entry.id;
				r.due    = entry.due;
				r.status = 1'b0;
				r.last   = (k == n - 1);
				queue_result(r);
			end
			if (n == 0) begin
				r.kind   = dotq_pkg::KIND_EMPTY;
				r.id     = '0;
				r.due    = now_cycle;
				r.status = 1'b0;
				r.last   = 1'b1;
				queue_result(r);
			end
			now_cycle = now_cycle + 32'd1;
		end
	endfunction

	// Offer one request; returns at the rising edge where it is accepted.
	task automatic send_request(logic cmd, logic [15:0] id, logic [31:0] due);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {due, id};
		do
			@(posedge clk);
		while (!s_tready);
		predict_response(cmd, id, due);
		requests_sent++;
	endtask

	// Drop valid and wait until every expected result has been seen.
	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_release_cap(logic [dotq_pkg::CAP_W-1:0] value);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		release_cap = value;
	endtask

	// Receiver side: random stalls, or a forced hold-off.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_tready <= hold_off ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Compare each accepted result against the oldest expectation.
	always @(posedge clk) begin
		dotq_pkg::res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				$error("Unexpected result: kind %0d id 0x%04h due 0x%08h", m_tuser[1:0],
					m_tdata[15:0], m_tdata[47:16]);
				mismatch_count++;
			end else begin
				want = expected_results[0];
				expected_results.delete(0);
				results_checked++;
				if (m_tuser[1:0] !== want.kind) begin
					$error("kind: expected %0d, got %0d", want.kind, m_tuser[1:0]);
					mismatch_count++;
				end
				if (m_tdata[15:0] !== want.id) begin
					$error("released_id: expected 0x%04h, got 0x%04h", want.id, m_tdata[15:0]);
					mismatch_count++;
				end
				if (m_tdata[47:16] !== want.due) begin
					$error("released_due: expected 0x%08h, got 0x%08h", want.due,
						m_tdata[47:16]);
					mismatch_count++;
				end
				if (m_tuser[2] !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, m_tuser[2]);
					mismatch_count++;
				end
				if (m_tlast !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, m_tlast);
					mismatch_count++;
				end
			end
		end
	end

	// Fill the queue past its depth, then release all 64 ties in one tick.
	task automatic test_queue_overflow();
		for (int i = 0; i < dotq_pkg::QUEUE_DEPTH_DEF + 2; i++)
			send_request(dotq_pkg::CMD_ADD, 16'($urandom),
				(i % 8 == 0) ? 32'd0 : now_cycle + 32'd1);
		send_request(dotq_pkg::CMD_TICK, 16'h0, 32'h0);
		send_request(dotq_pkg::CMD_TICK, 16'h0, 32'h0);
		wait_idle();
	endtask

	// Field extremes, due clamping, FIFO ties and empty ticks.
	task automatic test_directed_edges();
		logic [31:0] t0;
		t0 = now_cycle;
		send_request(dotq_pkg::CMD_TICK, 16'hFFFF, 32'hFFFF_FFFF);
		send_request(dotq_pkg::CMD_ADD, 16'hFFFF, 32'h0);
		send_request(dotq_pkg::CMD_ADD, 16'h0000, 32'hFFFF_FFFF);
		send_request(dotq_pkg::CMD_ADD, 16'h1234, t0 + 32'd1);
		send_request(dotq_pkg::CMD_ADD, 16'h5678, t0 + 32'd3);
		send_request(dotq_pkg::CMD_ADD, 16'hA5A5, t0 + 32'd3);
		send_request(dotq_pkg::CMD_ADD, 16'h5A5A, t0 + 32'd2);
		send_request(dotq_pkg::CMD_TICK, 16'h0, 32'h0);
		send_request(dotq_pkg::CMD_TICK, 16'h0, 32'h0);
		send_request(dotq_pkg::CMD_TICK, 16'h0, 32'h0);
		send_request(dotq_pkg::CMD_TICK, 16'h0, 32'h0);
		wait_idle();
	endtask

	// Cap of zero acts as one, above 64 acts as 64, a small cap defers tasks.
	task automatic test_release_cap();
		logic [dotq_pkg::CAP_W-1:0] caps[3];
		caps = '{7'd0, 7'd127, 7'd2};
		foreach (caps[c]) begin
			write_release_cap(caps[c]);
			for (int i = 0; i < 4; i++)
				send_request(dotq_pkg::CMD_ADD, 16'($urandom), now_cycle + 32'd1);
			repeat (3) send_request(dotq_pkg::CMD_TICK, 16'h0, 32'h0);
		end
		write_release_cap(dotq_pkg::CAP_RESET);
	endtask

	// Hold the receiver off while requests keep coming, so the input stalls.
	task automatic test_output_stall();
		fork
			begin
				hold_off = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_off = 1'b0;
			end
		join_none
		for (int i = 0; i < 6; i++)
			send_request(dotq_pkg::CMD_ADD, 16'($urandom),
				now_cycle + 32'($urandom_range(1, 2)));
		repeat (4) send_request(dotq_pkg::CMD_TICK, 16'h0, 32'h0);
		wait_idle();
	endtask

	// Random adds and ticks under four idle patterns, each with its own cap.
	task automatic test_random_traffic();
		int          send_pct[4];
		int          recv_pct[4];
		logic [6:0]  phase_cap[4];
		logic [31:0] due;
		int          pick;
		send_pct  = '{0, 86, 0, 22};
		recv_pct  = '{0, 0, 86, 22};
		phase_cap = '{7'd64, 7'($urandom_range(1, 3)), 7'($urandom_range(0, 127)), 7'd5};
		for (int p = 0; p < 4; p++) begin
			write_release_cap(phase_cap[p]);
			send_idle_pct  = send_pct[p];
			recv_stall_pct = recv_pct[p];
			for (int i = 0; i < RANDOM_ITEMS; i++) begin
				if ($urandom_range(1) == 1) begin
					send_request(dotq_pkg::CMD_TICK, 16'($urandom), 32'($urandom));
				end else begin
					pick = $urandom_range(99);
					if (pick < 60)
						due = now_cycle + 32'($urandom_range(1, 6));
					else if (pick < 80)
						due = now_cycle - 32'($urandom_range(1, 3));
					else if (pick < 95)
						due = now_cycle;
					else
						due = 32'($urandom);
					send_request(dotq_pkg::CMD_ADD, 16'($urandom), due);
				end
			end
		end
		send_idle_pct  = 0;
		recv_stall_pct = 0;
	endtask

	initial begin
		arst_n          = 1'b0;
		s_tvalid        = 1'b0;
		s_tdata         = '0;
		s_tuser         = dotq_pkg::CMD_ADD;
		cfg_we          = 1'b0;
		cfg_wdata       = '0;
		hold_off        = 1'b0;
		send_idle_pct   = 0;
		recv_stall_pct  = 0;
		cycle_count     = 0;
		mismatch_count  = 0;
		requests_sent   = 0;
		results_checked = 0;
		now_cycle       = '0;
		release_cap     = dotq_pkg::CAP_RESET;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		test_queue_overflow();
		test_directed_edges();
		test_release_cap();
		test_output_stall();
		test_random_traffic();

		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Checked %0d results from %0d requests in %0d cycles, %0d mismatches.",
			results_checked, requests_sent, cycle_count, mismatch_count);
		$display("Covered overflow drops, tie order, clamping, cap limits, a long stall and idles.");
		if (mismatch_count == 0) begin
			$display("[deadline_ordered_task_queue] OK");
		end else begin
			$display("[deadline_ordered_task_queue] ERROR");
		end
		$finish;
	end

endmodule
